FILE: src/ffba_pkg.sv
// Shared constants, types and helpers for the first-fit block allocator.
// Used by ffba_ctrl and the top level in src; it depends on nothing else.
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int BS_LOG2    = 12;
    localparam int ADDR_W     = 22;
    localparam int AMT_W      = 23;
    localparam int CFG_W      = 11;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int LIM_W   = $clog2(MAX_BLOCKS + 1);
    localparam int FIRST_W = ADDR_W - BS_LOG2;
    localparam int BLK_W   = AMT_W - BS_LOG2 + 1;
    // Wide enough for a first block plus a block count, and for the limit.
    localparam int SPAN_W  = (BLK_W + 1 > LIM_W) ? BLK_W + 1 : LIM_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_SET   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] byte_address;
        logic [AMT_W-1:0]  byte_amount;
        logic              mark_used;
    } t_req;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] alloc_address;
        logic              status;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    // Effective block count: the register saturated to the map size.
    function automatic logic [LIM_W-1:0] sat_limit(input logic [CFG_W-1:0] count);
        logic [31:0] wide;
        wide = 32'(count);
        if (wide > 32'(MAX_BLOCKS)) begin
            return LIM_W'(MAX_BLOCKS);
        end
        return LIM_W'(wide);
    endfunction

endpackage

FILE: src/ffba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; used for the block map of the allocator.
`timescale 1ns / 1ps

module ffba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ffba_ctrl.sv
// Request sequencer of the allocator: clearing pass, first-fit scan and run marking.
// Depends on ffba_pkg; drives the block map RAM through a t_ram_req struct.
`timescale 1ns / 1ps

module ffba_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  ffba_pkg::t_req           i_req,
    output logic                     o_req_ready,
    input  logic [ffba_pkg::CFG_W-1:0] i_block_count,
    output ffba_pkg::t_ram_req       o_ram,
    input  logic                     i_ram_rdata,
    output ffba_pkg::t_result        o_res,
    input  logic                     i_res_ready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

    t_state r_state;

    logic [1:0]                      r_kind;
    logic [ffba_pkg::FIRST_W-1:0]    r_first;
    logic [ffba_pkg::AMT_W-1:0]      r_amount;
    logic                            r_mark;
    logic [ffba_pkg::SPAN_W-1:0]     r_need;
    logic [ffba_pkg::SPAN_W-1:0]     r_run;
    logic [ffba_pkg::IDX_W-1:0]      r_start;
    logic [ffba_pkg::IDX_W-1:0]      r_pidx;
    logic                            r_pv;
    logic [ffba_pkg::SPAN_W-1:0]     r_cur;
    logic [ffba_pkg::SPAN_W-1:0]     r_end;
    logic                            r_val;
    logic [ffba_pkg::IDX_W-1:0]      r_clr;
    logic [ffba_pkg::ADDR_W-1:0]     r_res_addr;
    logic                            r_res_status;

    logic [ffba_pkg::SPAN_W-1:0] limit_ext;
    logic [ffba_pkg::SPAN_W-1:0] need;
    logic [ffba_pkg::AMT_W:0]    amt_up;
    logic [ffba_pkg::SPAN_W-1:0] blocks_sel;
    logic [ffba_pkg::SPAN_W-1:0] span_end;
    logic [ffba_pkg::SPAN_W-1:0] mark_end;
    logic [ffba_pkg::SPAN_W-1:0] run_new;
    logic [ffba_pkg::IDX_W-1:0]  start_now;
    logic                        found;
    logic                        can_issue;
    logic                        mark_busy;

    assign limit_ext = ffba_pkg::SPAN_W'(ffba_pkg::sat_limit(i_block_count));

    // Setup arithmetic on the latched request.
    assign need   = ffba_pkg::SPAN_W'((r_amount - ffba_pkg::AMT_W'(1)) >> ffba_pkg::BS_LOG2)
                    + ffba_pkg::SPAN_W'(1);
    assign amt_up = {1'b0, r_amount} + (ffba_pkg::AMT_W + 1)'((1 << ffba_pkg::BS_LOG2) - 1);

    always_comb begin
        if (r_kind == ffba_pkg::KIND_SET) begin
            blocks_sel = ffba_pkg::SPAN_W'(amt_up >> ffba_pkg::BS_LOG2);
        end else begin
            blocks_sel = ffba_pkg::SPAN_W'(r_amount >> ffba_pkg::BS_LOG2);
        end
    end

    assign span_end = ffba_pkg::SPAN_W'(r_first) + blocks_sel;
    assign mark_end = (span_end > limit_ext) ? limit_ext : span_end;

    // Scan step: the word read last cycle arrives now for block r_pidx.
    assign run_new   = r_run + ffba_pkg::SPAN_W'(1);
    assign start_now = (r_run == '0) ? r_pidx : r_start;
    assign found     = r_pv && !i_ram_rdata && (run_new == r_need);
    assign can_issue = (r_cur < limit_ext);
    assign mark_busy = (r_cur < r_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ffba_pkg::IDX_W'(1);
                    if (r_clr == ffba_pkg::IDX_W'(ffba_pkg::MAX_BLOCKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_kind   <= i_req.kind;
                        r_first  <= i_req.byte_address[ffba_pkg::ADDR_W-1:ffba_pkg::BS_LOG2];
                        r_amount <= i_req.byte_amount;
                        r_mark   <= i_req.mark_used;
                        r_state  <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_res_addr   <= '0;
                    r_res_status <= 1'b0;
                    case (r_kind)
                        ffba_pkg::KIND_ALLOC: begin
                            if (r_amount == '0 || need > limit_ext) begin
                                r_res_status <= 1'b1;
                                r_state      <= S_DONE;
                            end else begin
                                r_need  <= need;
                                r_run   <= '0;
                                r_cur   <= '0;
                                r_pv    <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end
                        ffba_pkg::KIND_FREE: begin
                            r_cur   <= ffba_pkg::SPAN_W'(r_first);
                            r_end   <= mark_end;
                            r_val   <= 1'b0;
                            r_state <= S_MARK;
                        end
                        ffba_pkg::KIND_SET: begin
                            r_cur   <= ffba_pkg::SPAN_W'(r_first);
                            r_end   <= mark_end;
                            r_val   <= r_mark;
                            r_state <= S_MARK;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SCAN: begin
                    r_pv <= can_issue && !found;
                    if (can_issue) begin
                        r_cur  <= r_cur + ffba_pkg::SPAN_W'(1);
                        r_pidx <= r_cur[ffba_pkg::IDX_W-1:0];
                    end
                    if (r_pv) begin
                        if (!i_ram_rdata) begin
                            r_start <= start_now;
                            r_run   <= run_new;
                        end else begin
                            r_run <= '0;
                        end
                    end
                    if (found) begin
                        r_cur      <= ffba_pkg::SPAN_W'(start_now);
                        r_end      <= ffba_pkg::SPAN_W'(start_now) + r_need;
                        r_val      <= 1'b1;
                        r_res_addr <= ffba_pkg::ADDR_W'({start_now, ffba_pkg::BS_LOG2'(0)});
                        r_state    <= S_MARK;
                    end else if (!r_pv && !can_issue) begin
                        r_res_status <= 1'b1;
                        r_state      <= S_DONE;
                    end
                end
                S_MARK: begin
                    if (mark_busy) begin
                        r_cur <= r_cur + ffba_pkg::SPAN_W'(1);
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_ram.raddr = r_cur[ffba_pkg::IDX_W-1:0];
        if (r_state == S_CLEAR) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = r_clr;
            o_ram.wdata = 1'b0;
        end else begin
            o_ram.we    = (r_state == S_MARK) && mark_busy;
            o_ram.waddr = r_cur[ffba_pkg::IDX_W-1:0];
            o_ram.wdata = r_val;
        end
    end

    assign o_req_ready         = (r_state == S_IDLE);
    assign o_res.valid         = (r_state == S_DONE);
    assign o_res.alloc_address = r_res_addr;
    assign o_res.status        = r_res_status;

    // The map is never written while a scan is reading it.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_ram.we)
        else $error("block map written during scan");

    // Marking never reaches past the managed block count.
    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MARK) && o_ram.we) |-> (r_cur < limit_ext))
        else $error("mark beyond block count");

    // A successful allocation returns a block-aligned address.
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.status) |->
            (o_res.alloc_address[ffba_pkg::BS_LOG2-1:0] == '0))
        else $error("unaligned allocation address");

    // One request at a time: after an accept the sequencer is busy.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("second request taken while busy");

endmodule

FILE: src/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: config register, output register,
// block map RAM (ffba_ram) and request sequencer (ffba_ctrl); depends on ffba_pkg.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+--------------------------------------------
//  request  | i_in_valid/o_in_stall | i_kind, i_byte_address, i_byte_amount,
//           |                       | i_mark_used
//  result   | o_out_valid/i_out_stall | o_alloc_address, o_status
//  config   | i_cfg_we              | i_cfg_data (block_count)
//
// After reset a clearing pass writes every entry of the block map (MAX_BLOCKS);
// requests are stalled then, configuration writes are taken.
// Free and set make one map write per block.
// Alloc scans the map up to the end of the first run that fits, then marks that run:
// the scan reads one map entry per cycle through the single read port.
// A finished result sits in the output register, so the next request is taken
// while it waits for the downstream side.
`timescale 1ns / 1ps

module first_fit_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_kind,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_byte_address,
    input  logic [ffba_pkg::AMT_W-1:0]    i_byte_amount,
    input  logic                          i_mark_used,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ffba_pkg::ADDR_W-1:0]   o_alloc_address,
    output logic                          o_status,
    input  logic                          i_cfg_we,
    input  logic [ffba_pkg::CFG_W-1:0]    i_cfg_data
);

    logic [ffba_pkg::CFG_W-1:0]  r_block_count;
    logic                        r_out_valid;
    logic [ffba_pkg::ADDR_W-1:0] r_out_addr;
    logic                        r_out_status;

    ffba_pkg::t_req      req;
    ffba_pkg::t_result   res;
    ffba_pkg::t_ram_req  ram;
    logic                ram_rdata;
    logic                req_ready;
    logic                res_ready;

    assign req.kind         = i_kind;
    assign req.byte_address = i_byte_address;
    assign req.byte_amount  = i_byte_amount;
    assign req.mark_used    = i_mark_used;

    // The output register takes a new beat when empty or being drained.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= ffba_pkg::CFG_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_count <= i_cfg_data;
            end
            if (res.valid && res_ready) begin
                r_out_valid  <= 1'b1;
                r_out_addr   <= res.alloc_address;
                r_out_status <= res.status;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    ffba_ram #(
        .WIDTH (1),
        .DEPTH (ffba_pkg::MAX_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_raddr (ram.raddr),
        .o_rdata (ram_rdata)
    );

    ffba_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_in_valid),
        .i_req         (req),
        .o_req_ready   (req_ready),
        .i_block_count (r_block_count),
        .o_ram         (ram),
        .i_ram_rdata   (ram_rdata),
        .o_res         (res),
        .i_res_ready   (res_ready)
    );

    assign o_in_stall      = !req_ready;
    assign o_out_valid     = r_out_valid;
    assign o_alloc_address = r_out_addr;
    assign o_status        = r_out_status;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for first_fit_block_allocator: directed and random alloc, free and set
// beats are checked against a block map kept in the bench. Depends on ffba_pkg and src RTL.

module tb_top;

    localparam logic [1:0] KIND_NONE    = 2'd3;
    localparam int unsigned BLOCK_BYTES = 1 << ffba_pkg::BS_LOG2;
    localparam int unsigned AMOUNT_MAX  = 4194304;
    localparam int unsigned ADDR_MAX    = (1 << ffba_pkg::ADDR_W) - 1;
    localparam int unsigned TAIL_CYCLES = 2200;

    typedef struct {
        logic [ffba_pkg::ADDR_W-1:0] address;
        logic                        status;
    } t_grant;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    ffba_pkg::t_req              req_beat = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [ffba_pkg::ADDR_W-1:0] alloc_address;
    logic                        status;
    logic                        cfg_we = 1'b0;
    logic [ffba_pkg::CFG_W-1:0]  cfg_data = '0;

    // Bench copy of the block map and the count register.
    bit                          used_blk [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::CFG_W-1:0]  blk_count = ffba_pkg::CFG_RESET;

    ffba_pkg::t_req    pending_q[$];
    t_grant            grant_q[$];
    int unsigned       live_first[$];
    int unsigned       live_len[$];
    t_grant            oldest_grant;
    bit                idle_en = 1'b1;
    bit                calm_tail = 1'b0;
    int                gap_left = 0;
    int                stall_left = 0;
    int                fail_count = 0;

    first_fit_block_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_kind          (req_beat.kind),
        .i_byte_address  (req_beat.byte_address),
        .i_byte_amount   (req_beat.byte_amount),
        .i_mark_used     (req_beat.mark_used),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_alloc_address (alloc_address),
        .o_status        (status),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned managed_blocks();
        if (int'(blk_count) > ffba_pkg::MAX_BLOCKS) begin
            return ffba_pkg::MAX_BLOCKS;
        end
        return int'(blk_count);
    endfunction

    // Blocks at or past the managed count are never touched.
    function automatic void mark_blocks(int unsigned first, int unsigned count, bit value);
        int unsigned stop;
        int unsigned b;
        stop = first + count;
        if (stop > managed_blocks()) begin
            stop = managed_blocks();
        end
        for (b = first; b < stop; b++) begin
            used_blk[b] = value;
        end
    endfunction

    function automatic t_grant first_fit(int unsigned amount);
        t_grant      g;
        int unsigned lim;
        int unsigned need;
        int unsigned run;
        int unsigned first;
        int unsigned b;
        g.address = '0;
        g.status  = 1'b1;
        lim = managed_blocks();
        if (amount == 0) begin
            return g;
        end
        need = ((amount - 1) >> ffba_pkg::BS_LOG2) + 1;
        if (need > lim) begin
            return g;
        end
        run = 0;
        first = 0;
        for (b = 0; b < lim; b++) begin
            if (!used_blk[b]) begin
                if (run == 0) begin
                    first = b;
                end
                run++;
                if (run == need) begin
                    break;
                end
            end else begin
                run = 0;
            end
        end
        if (run < need) begin
            return g;
        end
        mark_blocks(first, need, 1'b1);
        // Remember live runs so that later frees hit real allocations.
        live_first.push_back(first);
        live_len.push_back(need);
        if (live_first.size() > 64) begin
            void'(live_first.pop_front());
            void'(live_len.pop_front());
        end
        g.address = ffba_pkg::ADDR_W'(first << ffba_pkg::BS_LOG2);
        g.status  = 1'b0;
        return g;
    endfunction

    function automatic void predict_request(ffba_pkg::t_req r);
        t_grant      g;
        int unsigned first;
        g.address = '0;
        g.status  = 1'b0;
        first = r.byte_address >> ffba_pkg::BS_LOG2;
        case (r.kind)
            ffba_pkg::KIND_ALLOC: begin
                g = first_fit(r.byte_amount);
            end
            ffba_pkg::KIND_FREE: begin
                mark_blocks(first, r.byte_amount >> ffba_pkg::BS_LOG2, 1'b0);
            end
            ffba_pkg::KIND_SET: begin
                mark_blocks(first,
                            (int'(r.byte_amount) + BLOCK_BYTES - 1) >> ffba_pkg::BS_LOG2,
                            r.mark_used);
            end
            default: begin
            end
        endcase
        grant_q.push_back(g);
    endfunction

    function automatic ffba_pkg::t_req make_req(logic [1:0] kind, int unsigned addr,
                                                int unsigned amount, bit mark);
        ffba_pkg::t_req r;
        r.kind         = kind;
        r.byte_address = ffba_pkg::ADDR_W'(addr);
        r.byte_amount  = ffba_pkg::AMT_W'(amount);
        r.mark_used    = mark;
        return r;
    endfunction

    function automatic ffba_pkg::t_req random_request();
        ffba_pkg::t_req r;
        int unsigned    lim;
        int unsigned    pick;
        int unsigned    blocks;
        int unsigned    idx;
        int unsigned    first;
        lim = managed_blocks();
        pick = $urandom_range(0, 99);
        blocks = $urandom_range(1, 8);
        if (pick < 2) begin
            return make_req(ffba_pkg::KIND_ALLOC, $urandom, 0, $urandom_range(0, 1));
        end
        if (pick < 5) begin
            return make_req(ffba_pkg::KIND_ALLOC, $urandom, $urandom_range(0, AMOUNT_MAX),
                            $urandom_range(0, 1));
        end
        if (pick < 45) begin
            return make_req(ffba_pkg::KIND_ALLOC, $urandom,
                            (blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES),
                            $urandom_range(0, 1));
        end
        if (pick < 70 && live_first.size() != 0) begin
            idx = $urandom_range(0, live_first.size() - 1);
            r = make_req(ffba_pkg::KIND_FREE,
                         (live_first[idx] << ffba_pkg::BS_LOG2)
                             + $urandom_range(0, BLOCK_BYTES - 1),
                         live_len[idx] * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1),
                         $urandom_range(0, 1));
            live_first.delete(idx);
            live_len.delete(idx);
            return r;
        end
        if (pick < 85) begin
            first = $urandom_range(0, lim);
            if (first > ffba_pkg::MAX_BLOCKS - 1) begin
                first = ffba_pkg::MAX_BLOCKS - 1;
            end
            return make_req(ffba_pkg::KIND_SET,
                            (first << ffba_pkg::BS_LOG2) + $urandom_range(0, BLOCK_BYTES - 1),
                            $urandom_range(0, 8 * BLOCK_BYTES), $urandom_range(0, 1));
        end
        if (pick < 95) begin
            return make_req(ffba_pkg::KIND_FREE, $urandom_range(0, ADDR_MAX),
                            $urandom_range(0, 16 * BLOCK_BYTES), $urandom_range(0, 1));
        end
        return make_req(KIND_NONE, $urandom_range(0, ADDR_MAX), $urandom_range(0, AMOUNT_MAX),
                        $urandom_range(0, 1));
    endfunction

    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid || grant_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_count(int unsigned value);
        wait_idle();
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= ffba_pkg::CFG_W'(value);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        blk_count = ffba_pkg::CFG_W'(value);
    endtask

    task automatic feed_random(int count);
        int k;
        for (k = 0; k < count; k++) begin
            while (pending_q.size() >= 4) begin
                @(negedge i_clk);
            end
            if (k % 16 == 0 && !calm_tail) begin
                idle_en = ($urandom_range(0, 3) != 0);
            end
            pending_q.push_back(random_request());
        end
    endtask

    task automatic push_req(logic [1:0] kind, int unsigned addr, int unsigned amount, bit mark);
        pending_q.push_back(make_req(kind, addr, amount, mark));
    endtask

    // Request driver: one beat held until accepted, with random gaps between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_request(req_beat);
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() != 0 && idle_en && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    req_beat <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (grant_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected beat, expected none, got address %h status %0d",
                             $time, alloc_address, status);
                end else begin
                    oldest_grant = grant_q.pop_front();
                    if (alloc_address !== oldest_grant.address) begin
                        fail_count++;
                        $display("%0t: alloc_address expected %h, got %h",
                                 $time, oldest_grant.address, alloc_address);
                    end
                    if (status !== oldest_grant.status) begin
                        fail_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, oldest_grant.status, status);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned phase_count [8];
        int p;
        phase_count = '{1024, 2047, 1, 300, 64, 0, 0, 1024};
        phase_count[6] = $urandom_range(2, 1023);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_count(ffba_pkg::CFG_RESET);

        push_req(ffba_pkg::KIND_ALLOC, 0, 0, 1'b0);
        push_req(ffba_pkg::KIND_ALLOC, 0, 1, 1'b0);
        push_req(ffba_pkg::KIND_ALLOC, 0, BLOCK_BYTES, 1'b1);
        push_req(ffba_pkg::KIND_ALLOC, 0, BLOCK_BYTES + 1, 1'b0);
        push_req(ffba_pkg::KIND_ALLOC, 0, AMOUNT_MAX, 1'b0);
        // A free shorter than one block releases nothing; low address bits are ignored.
        push_req(ffba_pkg::KIND_FREE, BLOCK_BYTES, BLOCK_BYTES - 1, 1'b0);
        push_req(ffba_pkg::KIND_FREE, 2 * BLOCK_BYTES - 1, BLOCK_BYTES, 1'b0);
        push_req(ffba_pkg::KIND_ALLOC, 0, 1, 1'b0);
        push_req(ffba_pkg::KIND_SET, ADDR_MAX, 1, 1'b1);
        push_req(KIND_NONE, ADDR_MAX, AMOUNT_MAX, 1'b1);
        push_req(ffba_pkg::KIND_SET, 'h123456, 0, 1'b1);
        push_req(ffba_pkg::KIND_SET, 0, AMOUNT_MAX, 1'b0);
        push_req(ffba_pkg::KIND_ALLOC, 0, AMOUNT_MAX, 1'b0);
        push_req(ffba_pkg::KIND_FREE, 'h200000, AMOUNT_MAX, 1'b0);
        push_req(ffba_pkg::KIND_ALLOC, 0, 'h200000, 1'b0);

        // Small count: runs longer than the count and writes past it.
        write_count(7);
        push_req(ffba_pkg::KIND_FREE, 0, AMOUNT_MAX, 1'b0);
        push_req(ffba_pkg::KIND_ALLOC, 0, 8 * BLOCK_BYTES, 1'b0);
        push_req(ffba_pkg::KIND_SET, 5 * BLOCK_BYTES, 6 * BLOCK_BYTES, 1'b1);
        push_req(ffba_pkg::KIND_ALLOC, 0, 5 * BLOCK_BYTES, 1'b0);
        push_req(ffba_pkg::KIND_ALLOC, 0, 1, 1'b0);

        write_count(0);
        push_req(ffba_pkg::KIND_ALLOC, 0, 1, 1'b0);
        push_req(ffba_pkg::KIND_SET, 0, BLOCK_BYTES, 1'b0);

        // A count above the map size saturates.
        write_count(2047);
        push_req(ffba_pkg::KIND_ALLOC, 0, 1, 1'b0);
        push_req(ffba_pkg::KIND_SET, 0, AMOUNT_MAX, 1'b0);
        push_req(ffba_pkg::KIND_ALLOC, 0, AMOUNT_MAX, 1'b0);

        for (p = 0; p < 8; p++) begin
            write_count(phase_count[p]);
            if (p == 5) begin
                feed_random(20);
            end else if (p == 7) begin
                feed_random(20);
                calm_tail = 1'b1;
                idle_en = 1'b0;
                feed_random(60);
            end else begin
                feed_random(75);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #80000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
